/* hdl/pda_pkg.sv */
// Shared constants, types and the controller state encoding for the
// pairwise diversity accumulator. No dependencies.
package pda_pkg;

  localparam int MaxInd   = 256;
  localparam int IdxW     = $clog2(MaxInd);
  localparam int CntW     = $clog2(MaxInd + 1);
  localparam int Cells    = MaxInd * (MaxInd + 1) / 2;
  localparam int CaddrW   = $clog2(Cells);
  localparam int AccW     = 48;
  localparam int CntFldW  = 8;
  localparam int CovW     = CntFldW + 1;
  localparam int WincW    = 2 * CovW;
  localparam int DincW    = 2 * CntFldW + 1;
  localparam int OutW     = 48;
  localparam int CfgAddrW = 2;

  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_READ  = 1'b1;
  localparam logic [CfgAddrW-1:0] REG_NUM_IND = '0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RADDR,
    ST_RDATA
  } state_t;

  typedef struct packed {
    logic clr;
    logic load_item;
    logic issue;
    logic load_read;
    logic rd_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic j_last;
    logic pipe_idle;
    logic out_busy;
  } status_t;

endpackage

/* hdl/pda_if.sv */
// Valid/ready channel interfaces for the input items and the results.
// Depends on pda_pkg.
interface pda_in_if import pda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [CntFldW-1:0] major_count;
  logic [CntFldW-1:0] minor_count;
  logic [IdxW-1:0]    read_row;
  logic [IdxW-1:0]    read_col;

  modport source (output valid, req_type, major_count, minor_count, read_row, read_col,
                  input ready);
  modport sink (input valid, req_type, major_count, minor_count, read_row, read_col,
                output ready);
endinterface

interface pda_out_if import pda_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OutW-1:0] weight_sum;
  logic [OutW-1:0] diff_sum;
  logic            cell_ok;

  modport source (output valid, weight_sum, diff_sum, cell_ok, input ready);
  modport sink (input valid, weight_sum, diff_sum, cell_ok, output ready);
endinterface

/* hdl/pda_ctrl.sv */
// Controller state machine: clearing pass, per-item cell sweep and cell reads.
// Depends on pda_pkg.
module pda_ctrl import pda_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_req_type,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        // A read waits until the previous result has been taken.
        in_ready = !(in_req_type == REQ_READ && st.out_busy);
        if (in_valid && in_ready) begin
          if (in_req_type == REQ_COUNT) begin
            cmd.load_item = 1'b1;
            state_nxt     = ST_SWEEP;
          end else begin
            cmd.load_read = 1'b1;
            state_nxt     = ST_RADDR;
          end
        end
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        if (st.j_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (st.pipe_idle) state_nxt = ST_IDLE;
      end
      ST_RADDR: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RDATA;
      end
      ST_RDATA: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

/* hdl/pda_dp.sv */
// Datapath: locus pair memory, accumulator memory, three-stage update pipe
// and the result register. Depends on pda_pkg.
module pda_dp import pda_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic [CntW-1:0]    n_eff,
  input  logic [CntFldW-1:0] in_major,
  input  logic [CntFldW-1:0] in_minor,
  input  logic [IdxW-1:0]    in_row,
  input  logic [IdxW-1:0]    in_col,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OutW-1:0]    out_weight,
  output logic [OutW-1:0]    out_diff,
  output logic               out_ok
);

  logic [2*AccW-1:0]    acc_mem [Cells];
  logic [2*CntFldW-1:0] loc_mem [MaxInd];

  logic [CaddrW-1:0]  clr_r;
  logic [CntW-1:0]    idx_r;
  logic [IdxW-1:0]    cur_i_r, j_r;
  logic [CntFldW-1:0] cur_maj_r, cur_min_r;
  logic [CaddrW-1:0]  base_r, rd_addr_r;
  logic               rd_ok_r;

  logic [2*AccW-1:0]    acc_rd_r, acc_q_r;
  logic [2*CntFldW-1:0] loc_rd_r;
  logic                 s1_v_r, s2_v_r, diag1_r;
  logic [CaddrW-1:0]    a1_r, a2_r;
  logic [WincW-1:0]     winc_r;
  logic [DincW-1:0]     dinc_r;

  logic               out_valid_r, out_ok_r;
  logic [OutW-1:0]    out_w_r, out_d_r;

  logic [CntW-1:0]    i_sel, i_inc;
  logic [CaddrW-1:0]  sweep_addr, rd_addr_nxt, mem_raddr;
  logic [CovW-1:0]    ci, cj;
  logic [CntFldW-1:0] mj, nj;
  logic [AccW:0]      w_sum, d_sum;
  logic [AccW-1:0]    w_new, d_new;

  // Index wraps first if the count was lowered below it.
  assign i_sel       = (idx_r >= n_eff) ? '0 : idx_r;
  assign i_inc       = i_sel + CntW'(1);
  assign sweep_addr  = base_r + CaddrW'(j_r);
  assign rd_addr_nxt = ((CaddrW'(in_row) * (CaddrW'(in_row) + CaddrW'(1))) >> 1)
                       + CaddrW'(in_col);
  assign mem_raddr   = cmd.issue ? sweep_addr : rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      idx_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + CaddrW'(1);
      if (cmd.load_item) idx_r <= (i_inc >= n_eff) ? '0 : i_inc;
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur_i_r   <= i_sel[IdxW-1:0];
      cur_maj_r <= in_major;
      cur_min_r <= in_minor;
      base_r    <= (CaddrW'(i_sel) * (CaddrW'(i_sel) + CaddrW'(1))) >> 1;
      j_r       <= '0;
      loc_mem[i_sel[IdxW-1:0]] <= {in_major, in_minor};
    end
    if (cmd.issue) j_r <= j_r + IdxW'(1);
    if (cmd.load_read) begin
      rd_addr_r <= rd_addr_nxt;
      rd_ok_r   <= (in_col <= in_row) && (CntW'(in_row) < n_eff);
    end
    if (cmd.issue || cmd.rd_issue) acc_rd_r <= acc_mem[mem_raddr];
    loc_rd_r <= loc_mem[j_r];
    a1_r     <= sweep_addr;
    diag1_r  <= (j_r == cur_i_r);
    if (cmd.clr) begin
      acc_mem[clr_r] <= '0;
    end else if (s2_v_r) begin
      acc_mem[a2_r] <= {w_new, d_new};
    end
    if (cmd.out_load) begin
      out_ok_r <= rd_ok_r;
      out_w_r  <= rd_ok_r ? OutW'(acc_rd_r[2*AccW-1:AccW]) : '0;
      out_d_r  <= rd_ok_r ? OutW'(acc_rd_r[AccW-1:0]) : '0;
    end
  end

  // Stage one: products. Zero coverage gives zero increments, so every
  // cell of the sweep is written back.
  assign ci = CovW'(cur_maj_r) + CovW'(cur_min_r);
  assign mj = loc_rd_r[2*CntFldW-1:CntFldW];
  assign nj = loc_rd_r[CntFldW-1:0];
  assign cj = CovW'(mj) + CovW'(nj);

  always_ff @(posedge clk) begin
    a2_r    <= a1_r;
    acc_q_r <= acc_rd_r;
    if (diag1_r) begin
      winc_r <= (ci == '0) ? '0 : WincW'(ci) * WincW'(ci - CovW'(1));
      dinc_r <= DincW'(cur_maj_r) * DincW'(cur_min_r) << 1;
    end else begin
      winc_r <= WincW'(ci) * WincW'(cj);
      dinc_r <= DincW'(cur_maj_r) * DincW'(nj) + DincW'(mj) * DincW'(cur_min_r);
    end
  end

  // Stage two: saturating add.
  assign w_sum = {1'b0, acc_q_r[2*AccW-1:AccW]} + (AccW+1)'(winc_r);
  assign d_sum = {1'b0, acc_q_r[AccW-1:0]} + (AccW+1)'(dinc_r);
  assign w_new = w_sum[AccW] ? '1 : w_sum[AccW-1:0];
  assign d_new = d_sum[AccW] ? '1 : d_sum[AccW-1:0];

  assign st.clr_last  = (clr_r == CaddrW'(Cells - 1));
  assign st.j_last    = (j_r == cur_i_r);
  assign st.pipe_idle = !s1_v_r && !s2_v_r;
  assign st.out_busy  = out_valid_r;

  assign out_valid  = out_valid_r;
  assign out_weight = out_w_r;
  assign out_diff   = out_d_r;
  assign out_ok     = out_ok_r;

endmodule

/* hdl/pairwise_diversity_accumulator.sv */
// Top level: configuration register port, controller and datapath.
// Depends on pda_pkg, pda_if, pda_ctrl and pda_dp.

// After reset the block runs a clearing pass over every cell of the
// accumulator memory and takes no item until it ends. A count item then
// sweeps cells 0 to i of row i, where i is the individual's place in the
// locus, one accumulator cell per cycle through the one read port and the one
// write port of the accumulator memory. A read request passes an address
// state and a data state, and waits while an earlier result has not been transferred.
module pairwise_diversity_accumulator import pda_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  pda_in_if.sink              in_ch,
  pda_out_if.source           out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [CntW-1:0] num_r;
  logic [CntW-1:0] n_eff;
  cmd_t            cmd;
  status_t         st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= CntW'(MaxInd);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_NUM_IND) begin
      num_r <= cfg_pwdata[CntW-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_NUM_IND) ? 32'(num_r) : '0;

  always_comb begin
    if (num_r == '0) begin
      n_eff = CntW'(1);
    end else if (num_r > CntW'(MaxInd)) begin
      n_eff = CntW'(MaxInd);
    end else begin
      n_eff = num_r;
    end
  end

  pda_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .st          (st),
    .cmd         (cmd)
  );

  pda_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .n_eff      (n_eff),
    .in_major   (in_ch.major_count),
    .in_minor   (in_ch.minor_count),
    .in_row     (in_ch.read_row),
    .in_col     (in_ch.read_col),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_weight (out_ch.weight_sum),
    .out_diff   (out_ch.diff_sum),
    .out_ok     (out_ch.cell_ok)
  );

endmodule
